// ===== hw/rtl/snp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// snp_pkg: shared types and constants of the non-prime accumulator
// Command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package snp_pkg;

    // Default width of the tested value.
    localparam int VALUE_WIDTH_DEF = 32;
    // Width of the running sum, fixed at 32 bits.
    localparam int SUM_W = 32;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture an input word, set divisor to 2
        logic start_div;  // begin the remainder of value by divisor
        logic div_step;   // one restoring remainder step
        logic next_j;     // advance divisor and its square
        logic finish;     // write result word and update the sum
        logic prime;      // verdict for the current value
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic le_one;     // value is one or less
        logic sq_gt;      // divisor squared exceeds value
        logic div_last;   // last remainder step in progress
        logic rem_zero;   // remainder is zero
        logic out_busy;   // result register full and not taken this cycle
    } t_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/snp_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// snp_dp: trial division datapath
// Divisor and square registers, bit-serial remainder, sum and result word.
// ----------------------------------------------------------------------------
module snp_dp #(
    parameter int VALUE_WIDTH = snp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [VALUE_WIDTH-1:0]   i_value,
    input  wire logic                     i_first,
    input  wire snp_pkg::t_cmd            i_cmd,
    output snp_pkg::t_sts                 o_sts,
    input  wire logic                     i_m_tready,
    output logic                          o_m_tvalid,
    output logic                          o_prime,
    output logic [snp_pkg::SUM_W-1:0]     o_sum
);

    localparam int W     = VALUE_WIDTH;
    // Divisor never passes sqrt(2^(W-1)) + 1.
    localparam int JW    = (W - 1) / 2 + 2;
    localparam int CW    = $clog2(W - 1);
    localparam int EXT_W = (W > snp_pkg::SUM_W) ? W : snp_pkg::SUM_W;

    logic signed [W-1:0]           r_value;
    logic                          r_first;
    logic [JW-1:0]                 r_j;
    logic [W-1:0]                  r_sq;
    logic [JW-1:0]                 r_rem;
    logic [W-2:0]                  r_dvd;
    logic [CW-1:0]                 r_cnt;
    logic [snp_pkg::SUM_W-1:0]     r_sum;
    logic [snp_pkg::SUM_W-1:0]     n_sum;
    logic [snp_pkg::SUM_W-1:0]     r_out_sum;
    logic                          r_out_prime;
    logic                          r_out_valid;

    logic [JW:0]                   w_trial;
    logic [JW:0]                   w_j_ext;
    logic [EXT_W-1:0]              w_ext;
    logic [snp_pkg::SUM_W-1:0]     w_base;

    assign w_trial = {r_rem, r_dvd[W-2]};
    assign w_j_ext = {1'b0, r_j};
    assign w_ext   = EXT_W'(r_value);
    assign w_base  = r_first ? '0 : r_sum;
    assign n_sum   = i_cmd.prime ? w_base : w_base + w_ext[snp_pkg::SUM_W-1:0];

    assign o_sts.le_one   = (r_value <= $signed(W'(1)));
    assign o_sts.sq_gt    = (r_sq > {1'b0, r_value[W-2:0]});
    assign o_sts.div_last = (r_cnt == '0);
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_sts.out_busy = r_out_valid & ~i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_prime    = r_out_prime;
    assign o_sum      = r_out_sum;

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_first <= i_first;
            r_j     <= JW'(2);
            r_sq    <= W'(4);
        end else if (i_cmd.next_j) begin
            // (j+1)^2 = j^2 + 2j + 1
            r_sq <= r_sq + W'({r_j, 1'b1});
            r_j  <= r_j + JW'(1);
        end
        if (i_cmd.start_div) begin
            r_rem <= '0;
            r_dvd <= r_value[W-2:0];
            r_cnt <= CW'(W - 2);
        end else if (i_cmd.div_step) begin
            r_rem <= (w_trial >= w_j_ext) ? JW'(w_trial - w_j_ext) : JW'(w_trial);
            r_dvd <= r_dvd << 1;
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.finish) begin
            r_out_sum   <= n_sum;
            r_out_prime <= i_cmd.prime;
        end
    end

    // Sum and result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_sum       <= n_sum;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_sq_tracks_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_div |-> r_sq == W'(r_j) * W'(r_j))
        else $error("divisor square out of step with divisor");

    a_rem_below_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> r_rem < r_j)
        else $error("partial remainder not below divisor");

endmodule
`default_nettype wire

// ===== hw/rtl/snp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// snp_ctrl: trial division sequencer
// Steps divisor checks, remainder passes and result hand-off.
// ----------------------------------------------------------------------------
module snp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire snp_pkg::t_sts     i_sts,
    output snp_pkg::t_cmd          o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_TEST,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_prime;

    assign o_s_tready      = (r_state == S_IDLE);
    assign o_cmd.load      = (r_state == S_IDLE) & i_s_tvalid;
    assign o_cmd.start_div = (r_state == S_CHECK) & ~i_sts.le_one & ~i_sts.sq_gt;
    assign o_cmd.div_step  = (r_state == S_DIV);
    assign o_cmd.next_j    = (r_state == S_TEST) & ~i_sts.rem_zero;
    assign o_cmd.finish    = (r_state == S_DONE) & ~i_sts.out_busy;
    assign o_cmd.prime     = r_prime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prime <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (i_sts.le_one) begin
                        r_prime <= 1'b0;
                        r_state <= S_DONE;
                    end else if (i_sts.sq_gt) begin
                        r_prime <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_sts.div_last) begin
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (i_sts.rem_zero) begin
                        r_prime <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_DONE: begin
                    if (!i_sts.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_small_nonprime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) && i_sts.le_one |=> (r_state == S_DONE) && !r_prime)
        else $error("value of one or less not marked non-prime");

    a_div_to_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && i_sts.div_last |=> (r_state == S_TEST))
        else $error("remainder pass did not end in test");

endmodule
`default_nettype wire

// ===== hw/rtl/sum_of_nonprimes_trial_division_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sum_of_nonprimes_trial_division_top: non-prime accumulator
// Tests each value for primality by trial division and sums the non-primes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one word per value. s_axis_tdata carries the value in its
//   low VALUE_WIDTH bits (two's complement, upper pad bits ignored);
//   s_axis_tuser is the first-of-batch flag, which clears the running sum
//   before this value is counted.
//   Master channel: one word per input word. m_axis_tuser is the prime flag,
//   m_axis_tdata the running sum of non-prime values after this word,
//   wrapping modulo 2^32. Values of one or less, negatives included, count
//   as non-prime and are added as their low 32 bits.
//   One value at a time. Values of one or less, and 2 and 3, are settled by
//   the bound check alone. Otherwise each trial divisor j takes one bound
//   check, VALUE_WIDTH - 1 remainder steps and one test, so a prime v tries
//   each j from 2 to floor(sqrt(v)); a composite stops at its least factor.
//   s_axis_tready is high only while no value is in work; a finished result
//   sits in the output register, so the next value is taken while it waits.
//   A stalled receiver holds the result and the sequencer waits to write the
//   next one. Reset (synchronous, active low) clears the sum and drops
//   m_axis_tvalid.
// ----------------------------------------------------------------------------
module sum_of_nonprimes_trial_division_top #(
    parameter int VALUE_WIDTH = snp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave channel
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // value
    input  wire logic                               s_axis_tuser,  // first_of_batch
    // master channel
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [snp_pkg::SUM_W-1:0]               m_axis_tdata,  // nonprime_sum
    output logic                                    m_axis_tuser   // is_prime
);

    snp_pkg::t_cmd w_cmd;
    snp_pkg::t_sts w_sts;

    // Sequencer: bound check, remainder passes, result hand-off.
    snp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath: divisor, square, remainder, running sum, result register.
    snp_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_first    (s_axis_tuser),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_prime    (m_axis_tuser),
        .o_sum      (m_axis_tdata)
    );

endmodule
`default_nettype wire
